// ===== sv/rssp_pkg.sv =====
`default_nettype none

package rssp_pkg;

  typedef enum logic [1:0] {
    OP_TICK   = 2'd0,
    OP_CLEAR  = 2'd1,
    OP_APPEND = 2'd2,
    OP_START  = 2'd3
  } opcode_t;

  // One step of the profile. The heating flag is worked out when the step is
  // appended, from the target of the step appended just before it.
  typedef struct packed {
    logic               heating;
    logic [13:0]        ramp;
    logic signed [11:0] target;
    logic [13:0]        hold;
  } step_entry_t;

  // Measured temperature in 1/16 degree to setpoint units of 1/3600 degree.
  localparam logic signed [24:0] TEMP_SCALE = 25'sd225;
  // Whole degrees to setpoint units.
  localparam logic signed [24:0] HOUR_SCALE = 25'sd3600;
  // Hold minutes to seconds.
  localparam logic [19:0]        MIN_SCALE  = 20'd60;

endpackage

`default_nettype wire

// ===== sv/rssp_ram.sv =====
`default_nettype none

module rssp_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 16,
  parameter int AW    = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
  input  wire logic             clk,
  input  wire logic             we,
  input  wire logic [AW-1:0]    waddr,
  input  wire logic [WIDTH-1:0] wdata,
  input  wire logic [AW-1:0]    raddr,
  output logic      [WIDTH-1:0] rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  // Write-first: a read of the address being written returns the new data.
  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    if (we && (waddr == raddr)) begin
      rdata <= wdata;
    end else begin
      rdata <= mem[raddr];
    end
  end

endmodule

`default_nettype wire

// ===== sv/ramp_soak_setpoint_profiler.sv =====
`default_nettype none

// Ramp-and-soak setpoint profiler.
//
// The host issues one command item at a time on start together with opcode
// and the step fields. An item is taken at every clock edge where start is
// high and busy is low; busy never rises, so an item may be issued in every
// cycle. Opcodes: tick (once per second of a run), clear, append a step to
// the table, and start a run from the measured temperature.
//
// Every item produces exactly one result: done pulses for one cycle, in the
// cycle after the item was taken, and the result ports show the profile
// state after that item. The profile state stays on the ports until the next
// item, while finished and status are high only together with that done;
// the receiver cannot stall the block, so no result is ever held back.
// Each item is handled as it arrives: the step table is a small RAM
// whose read address tracks the active step, so the entry for the next item
// is already on the registered read port when that item arrives.
//
// Reset clears the step count, progress, setpoint and heater mode. The step
// table itself is not cleared; only entries below the step count are read.

module ramp_soak_setpoint_profiler #(
  parameter int MAX_STEPS = 16
) (
  input  wire logic                             clk,
  input  wire logic                             rst,
  input  wire logic                             start,
  output logic                                  busy,
  input  wire logic [1:0]                       opcode,
  input  wire logic signed [15:0]               measured_temp,
  input  wire logic [13:0]                      step_ramp,
  input  wire logic signed [11:0]               step_target,
  input  wire logic [13:0]                      step_hold_minutes,
  output logic                                  done,
  output logic signed [23:0]                    setpoint,
  output logic signed [23:0]                    start_setpoint,
  output logic [$clog2(MAX_STEPS + 1)-1:0]      step_index,
  output logic [23:0]                           runtime_seconds,
  output logic [19:0]                           hold_left,
  output logic                                  holding,
  output logic                                  heater_on,
  output logic                                  finished,
  output logic                                  status
);

  import rssp_pkg::*;

  localparam int CW = $clog2(MAX_STEPS + 1);
  localparam int AW = (MAX_STEPS > 1) ? $clog2(MAX_STEPS) : 1;

  // Profile state. The result ports are these registers themselves; the
  // hold count is kept at zero whenever no hold is running.
  logic [CW-1:0]      step_count, step_count_next;
  logic [CW-1:0]      step_index_next;
  logic signed [23:0] setpoint_next, start_setpoint_next;
  logic [23:0]        runtime_seconds_next;
  logic [19:0]        hold_left_next;
  logic               holding_next, heater_on_next;
  logic               finished_next, status_next;
  logic signed [11:0] last_target;

  step_entry_t        cur;
  step_entry_t        new_entry;
  logic               table_we;

  logic signed [24:0] meas;
  logic signed [24:0] tgt;
  logic signed [25:0] sp_move;
  logic signed [25:0] sp_clamped;
  logic               reached;

  assign busy = 1'b0;

  // The read address follows the next active step, so the entry is ready
  // on the cycle after any change of the step.
  rssp_ram #(
    .WIDTH ($bits(step_entry_t)),
    .DEPTH (MAX_STEPS),
    .AW    (AW)
  ) u_table (
    .clk   (clk),
    .we    (table_we),
    .waddr (step_count[AW-1:0]),
    .wdata (new_entry),
    .raddr (step_index_next[AW-1:0]),
    .rdata (cur)
  );

  // A step is heating unless its target lies below the previous target.
  // The first step after a clear is always heating.
  always_comb begin
    new_entry.heating = (step_count == '0) || !(step_target < last_target);
    new_entry.ramp    = step_ramp;
    new_entry.target  = step_target;
    new_entry.hold    = step_hold_minutes;
  end

  // Setpoint arithmetic for a tick, all in 1/3600 degree units.
  assign meas = 25'(measured_temp) * TEMP_SCALE;
  assign tgt  = 25'(cur.target) * HOUR_SCALE;

  always_comb begin
    if (cur.heating) begin
      sp_move = 26'(setpoint) + 26'(cur.ramp);
    end else begin
      sp_move = 26'(setpoint) - 26'(cur.ramp);
    end
    if ((cur.heating && (sp_move >= 26'(tgt))) ||
        (!cur.heating && (sp_move <= 26'(tgt)))) begin
      sp_clamped = 26'(tgt);
    end else begin
      sp_clamped = sp_move;
    end
  end

  // The step is done ramping once both the setpoint and the kiln are at
  // the target; this only starts a hold when none is already running.
  assign reached = !holding && (sp_clamped == 26'(tgt)) &&
                   ((cur.heating && (meas >= tgt)) || (!cur.heating && (meas <= tgt)));

  always_comb begin
    step_count_next      = step_count;
    step_index_next      = step_index;
    setpoint_next        = setpoint;
    start_setpoint_next  = start_setpoint;
    runtime_seconds_next = runtime_seconds;
    hold_left_next       = hold_left;
    holding_next         = holding;
    heater_on_next       = heater_on;
    finished_next        = 1'b0;
    status_next          = 1'b0;
    table_we             = 1'b0;

    if (start) begin
      unique case (opcode_t'(opcode))
        OP_TICK: begin
          if (step_count != '0) begin
            if (step_index >= step_count) begin
              // Schedule ended: drop the table and shut the heater off.
              step_count_next      = '0;
              step_index_next      = '0;
              runtime_seconds_next = '0;
              hold_left_next       = '0;
              holding_next         = 1'b0;
              heater_on_next       = 1'b0;
              finished_next        = 1'b1;
            end else begin
              if (runtime_seconds != '1) begin
                runtime_seconds_next = runtime_seconds + 24'd1;
              end
              if (reached && (cur.hold != '0)) begin
                // The first second of the hold is counted on this tick.
                holding_next   = 1'b1;
                hold_left_next = 20'(cur.hold) * MIN_SCALE - 20'd1;
              end else if (reached) begin
                step_index_next = step_index + CW'(1);
              end else if (holding) begin
                if (hold_left <= 20'd1) begin
                  holding_next    = 1'b0;
                  hold_left_next  = '0;
                  step_index_next = step_index + CW'(1);
                end else begin
                  hold_left_next = hold_left - 20'd1;
                end
              end else begin
                setpoint_next = 24'(sp_clamped);
              end
            end
          end
        end
        OP_CLEAR: begin
          step_count_next      = '0;
          step_index_next      = '0;
          runtime_seconds_next = '0;
          hold_left_next       = '0;
          holding_next         = 1'b0;
          heater_on_next       = 1'b0;
        end
        OP_APPEND: begin
          if (step_count < CW'(MAX_STEPS)) begin
            table_we        = 1'b1;
            step_count_next = step_count + CW'(1);
          end else begin
            status_next = 1'b1;
          end
        end
        OP_START: begin
          // The table is kept; the run starts from the kiln temperature.
          step_index_next      = '0;
          runtime_seconds_next = '0;
          hold_left_next       = '0;
          holding_next         = 1'b0;
          setpoint_next        = 24'(meas);
          start_setpoint_next  = 24'(meas);
          heater_on_next       = 1'b1;
        end
        default: begin
          step_count_next = step_count;
        end
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      step_count      <= '0;
      step_index      <= '0;
      setpoint        <= '0;
      start_setpoint  <= '0;
      runtime_seconds <= '0;
      hold_left       <= '0;
      holding         <= 1'b0;
      heater_on       <= 1'b0;
      finished        <= 1'b0;
      status          <= 1'b0;
      done            <= 1'b0;
    end else begin
      step_count      <= step_count_next;
      step_index      <= step_index_next;
      setpoint        <= setpoint_next;
      start_setpoint  <= start_setpoint_next;
      runtime_seconds <= runtime_seconds_next;
      hold_left       <= hold_left_next;
      holding         <= holding_next;
      heater_on       <= heater_on_next;
      finished        <= finished_next;
      status          <= status_next;
      done            <= start;
    end
  end

  // Target of the most recently appended step, for the heating flag.
  always_ff @(posedge clk) begin
    if (table_we) begin
      last_target <= step_target;
    end
  end

endmodule

`default_nettype wire

// ===== dv/tb_ramp_soak_setpoint_profiler.sv =====
`default_nettype none

// Checks the ramp-and-soak setpoint profiler: every command item is run
// through a local model of the profile, and the single result that each item
// produces is compared field by field with the oldest prediction.
module tb_ramp_soak_setpoint_profiler;
  import rssp_pkg::*;

  localparam int TABLE_DEPTH  = 16;
  localparam int RUNTIME_CEIL = 16777215;
  localparam int CYCLE_LIMIT  = 400000;

  // Everything the block reports after one item, at the port widths.
  typedef struct packed {
    logic signed [23:0] sp;
    logic signed [23:0] start_sp;
    logic [4:0]         index;
    logic [23:0]        runtime;
    logic [19:0]        hold_left;
    logic               holding;
    logic               heater;
    logic               finished;
    logic               status;
  } profile_state_t;

  logic                clk;
  logic                rst = 1'b1;
  logic                start = 1'b0;
  opcode_t             opcode = OP_TICK;
  logic signed [15:0]  measured_temp = '0;
  logic [13:0]         step_ramp = '0;
  logic signed [11:0]  step_target = '0;
  logic [13:0]         step_hold_minutes = '0;
  logic                busy;
  logic                done;
  logic signed [23:0]  setpoint;
  logic signed [23:0]  start_setpoint;
  logic [4:0]          step_index;
  logic [23:0]         runtime_seconds;
  logic [19:0]         hold_left;
  logic                holding;
  logic                heater_on;
  logic                finished;
  logic                status;

  ramp_soak_setpoint_profiler uut (
    .clk               (clk),
    .rst               (rst),
    .start             (start),
    .busy              (busy),
    .opcode            (opcode),
    .measured_temp     (measured_temp),
    .step_ramp         (step_ramp),
    .step_target       (step_target),
    .step_hold_minutes (step_hold_minutes),
    .done              (done),
    .setpoint          (setpoint),
    .start_setpoint    (start_setpoint),
    .step_index        (step_index),
    .runtime_seconds   (runtime_seconds),
    .hold_left         (hold_left),
    .holding           (holding),
    .heater_on         (heater_on),
    .finished          (finished),
    .status            (status)
  );

  // Local copy of the profile. Setpoints are kept in 1/3600 degree, exactly
  // as the block keeps them, so the ramp per tick is the raw ramp value.
  int prof_ramp     [TABLE_DEPTH];
  int prof_goal_deg [TABLE_DEPTH];
  int prof_hold_min [TABLE_DEPTH];
  int prof_steps     = 0;
  int prof_cur       = 0;
  int prof_sp        = 0;
  int prof_start_sp  = 0;
  int prof_runtime   = 0;
  int prof_hold_secs = 0;
  bit prof_holding   = 1'b0;
  bit prof_heat      = 1'b0;

  // Predicted results waiting for the block, oldest first.
  profile_state_t predicted_states[$];

  int mismatch_count = 0;
  int results_seen   = 0;
  int items_taken    = 0;
  int cycle_count    = 0;
  int idle_pct       = 0;

  initial begin
    clk = 1'b0;
    forever #5 clk = ~clk;
  end

  // A run that hangs, for instance because a result never comes, ends here.
  always @(posedge clk) begin
    cycle_count++;
    if (cycle_count > CYCLE_LIMIT) begin
      $display("timeout after %0d cycles, %0d results outstanding", cycle_count,
               predicted_states.size());
      $display("RESULT: ERROR");
      $finish;
    end
  end

  task automatic report_mismatch(input string what, input longint got, input longint want);
    $display("mismatch on result %0d: %s got %0d, want %0d", results_seen, what, got, want);
    mismatch_count++;
  endtask

  // Clearing the run drops the table, the progress and the hold, but leaves
  // the setpoint and the captured start point where they are.
  task automatic wipe_progress();
    prof_steps     = 0;
    prof_cur       = 0;
    prof_runtime   = 0;
    prof_hold_secs = 0;
    prof_holding   = 1'b0;
  endtask

  // Applies one accepted item to the local profile and queues the result
  // that the block has to report for it.
  task automatic advance_profile(input opcode_t op, input logic signed [15:0] temp,
                                 input logic [13:0] ramp, input logic signed [11:0] goal_deg,
                                 input logic [13:0] hold_min);
    int meas;
    int goal;
    int nxt;
    bit warming;
    bit moved_on;
    bit fin;
    bit rej;
    profile_state_t r;
    meas = temp;
    meas = meas * 225;
    fin = 1'b0;
    rej = 1'b0;
    case (op)
      OP_TICK: begin
        if (prof_steps != 0 && prof_cur >= prof_steps) begin
          // The tick after the last step shuts the run down.
          wipe_progress();
          prof_heat = 1'b0;
          fin = 1'b1;
        end else if (prof_steps != 0) begin
          if (prof_runtime < RUNTIME_CEIL) prof_runtime++;
          goal = prof_goal_deg[prof_cur] * 3600;
          // The first step always heats; later ones cool when their target
          // lies below the target of the step before.
          warming = !(prof_cur != 0 && prof_goal_deg[prof_cur] < prof_goal_deg[prof_cur - 1]);
          nxt = warming ? prof_sp + prof_ramp[prof_cur] : prof_sp - prof_ramp[prof_cur];
          if (warming ? (nxt >= goal) : (nxt <= goal)) nxt = goal;
          moved_on = 1'b0;
          if (!prof_holding && nxt == goal && (warming ? (meas >= goal) : (meas <= goal))) begin
            if (prof_hold_min[prof_cur] > 0) begin
              prof_hold_secs = prof_hold_min[prof_cur] * 60;
              prof_holding = 1'b1;
            end else begin
              // Target reached with no hold: advance, setpoint left alone.
              prof_cur++;
              moved_on = 1'b1;
            end
          end
          if (!moved_on) begin
            if (prof_holding) begin
              // The tick that starts a hold already counts it down once.
              if (prof_hold_secs <= 1) begin
                prof_holding = 1'b0;
                prof_hold_secs = 0;
                prof_cur++;
              end else begin
                prof_hold_secs--;
              end
            end else begin
              prof_sp = nxt;
            end
          end
        end
      end
      OP_CLEAR: begin
        wipe_progress();
        prof_heat = 1'b0;
      end
      OP_APPEND: begin
        if (prof_steps < TABLE_DEPTH) begin
          prof_ramp[prof_steps] = ramp;
          prof_goal_deg[prof_steps] = goal_deg;
          prof_hold_min[prof_steps] = hold_min;
          prof_steps++;
        end else begin
          rej = 1'b1;
        end
      end
      default: begin
        // Start keeps the table but restarts progress from the measurement.
        prof_cur = 0;
        prof_runtime = 0;
        prof_hold_secs = 0;
        prof_holding = 1'b0;
        prof_sp = meas;
        prof_start_sp = meas;
        prof_heat = 1'b1;
      end
    endcase
    r.sp        = prof_sp[23:0];
    r.start_sp  = prof_start_sp[23:0];
    r.index     = prof_cur[4:0];
    r.runtime   = prof_runtime[23:0];
    r.hold_left = prof_holding ? prof_hold_secs[19:0] : 20'd0;
    r.holding   = prof_holding;
    r.heater    = prof_heat;
    r.finished  = fin;
    r.status    = rej;
    predicted_states.insert(predicted_states.size(), r);
  endtask

  // Offers one item, idling first as the current phase asks. The fields
  // change only at the falling edge; acceptance is judged at the rising edge.
  task automatic send_item(input opcode_t op, input logic signed [15:0] temp,
                           input logic [13:0] ramp, input logic signed [11:0] goal_deg,
                           input logic [13:0] hold_min);
    while ($urandom_range(99) < idle_pct) begin
      @(negedge clk);
      start <= 1'b0;
    end
    @(negedge clk);
    start             <= 1'b1;
    opcode            <= op;
    measured_temp     <= temp;
    step_ramp         <= ramp;
    step_target       <= goal_deg;
    step_hold_minutes <= hold_min;
    do @(posedge clk); while (busy);
    // A tick on an empty table changes nothing, so it does not count.
    if (!(op == OP_TICK && prof_steps == 0)) items_taken++;
    advance_profile(op, temp, ramp, goal_deg, hold_min);
  endtask

  function automatic logic signed [11:0] rand_target();
    int v;
    v = $urandom_range(2303);
    return 12'(v - 256);
  endfunction

  function automatic logic signed [15:0] rand_temp();
    int v;
    v = $urandom_range(36863);
    return 16'(v - 4096);
  endfunction

  // A measurement close to base (in 1/16 degree), kept inside the legal range.
  function automatic logic signed [15:0] temp_near(input int base, input int spread);
    int off;
    int v;
    off = $urandom_range(2 * spread);
    v = base + off - spread;
    if (v < -4096) v = -4096;
    if (v > 32767) v = 32767;
    return 16'(v);
  endfunction

  // Commands that ignore the step fields still get random values there.
  task automatic send_cmd(input opcode_t op, input logic signed [15:0] temp);
    send_item(op, temp, 14'($urandom_range(16383)), rand_target(),
              14'($urandom_range(16383)));
  endtask

  // Parks the bus and waits until every predicted result has come back.
  task automatic wait_for_drain();
    @(negedge clk);
    start <= 1'b0;
    while (predicted_states.size() != 0) @(posedge clk);
  endtask

  // Checker: the result is on the ports for the one cycle that done is high.
  always @(posedge clk) begin
    profile_state_t want;
    if (!rst && done) begin
      if (predicted_states.size() == 0) begin
        report_mismatch("result with nothing pending, setpoint", setpoint, 0);
      end else begin
        want = predicted_states.pop_front();
        if (setpoint !== want.sp) report_mismatch("setpoint", setpoint, want.sp);
        if (start_setpoint !== want.start_sp)
          report_mismatch("start_setpoint", start_setpoint, want.start_sp);
        if (step_index !== want.index) report_mismatch("step_index", step_index, want.index);
        if (runtime_seconds !== want.runtime)
          report_mismatch("runtime_seconds", runtime_seconds, want.runtime);
        if (hold_left !== want.hold_left)
          report_mismatch("hold_left", hold_left, want.hold_left);
        if (holding !== want.holding) report_mismatch("holding", holding, want.holding);
        if (heater_on !== want.heater) report_mismatch("heater_on", heater_on, want.heater);
        if (finished !== want.finished) report_mismatch("finished", finished, want.finished);
        if (status !== want.status) report_mismatch("status", status, want.status);
      end
      results_seen++;
    end
  end

  // Straight after reset: a tick on the empty table must change nothing, and
  // a start with no steps only captures the measurement and turns heat on.
  task automatic test_empty_table();
    send_item(OP_TICK, 16'sd32767, 14'd16383, 12'sd2047, 14'd16383);
    send_item(OP_START, -16'sd4096, 14'd0, -12'sd256, 14'd0);
  endtask

  // One heating step starting a degree below its target. The tick that
  // reaches the target advances without writing the setpoint, and the next
  // tick runs past the last step, shuts the heater off and flags the end.
  task automatic test_schedule_end();
    send_item(OP_APPEND, 16'sd0, 14'd16383, 12'sd0, 14'd0);
    send_item(OP_START, -16'sd16, 14'd0, 12'sd0, 14'd0);
    send_item(OP_TICK, 16'sd0, 14'd0, 12'sd0, 14'd0);
    send_item(OP_TICK, 16'sd0, 14'd0, 12'sd0, 14'd0);
  endtask

  // A heating step followed by a cooling step with a one minute hold. The
  // tick that reaches the cooling target starts the hold and counts it once;
  // the setpoint stays put while the hold runs.
  task automatic test_cooling_hold();
    send_item(OP_APPEND, 16'sd0, 14'd16383, 12'sd2, 14'd0);
    send_item(OP_APPEND, 16'sd0, 14'd3600, 12'sd1, 14'd1);
    send_item(OP_START, 16'sd0, 14'd0, 12'sd0, 14'd0);
    send_item(OP_TICK, 16'sd32, 14'd0, 12'sd0, 14'd0);
    send_item(OP_TICK, 16'sd16, 14'd0, 12'sd0, 14'd0);
    send_item(OP_TICK, 16'sd20, 14'd0, 12'sd0, 14'd0);
  endtask

  // Fills the rest of the table with extreme step values while the hold is
  // still running, has one more append rejected, then clears everything.
  task automatic test_full_table();
    int i;
    for (i = 2; i < TABLE_DEPTH; i++) begin
      send_item(OP_APPEND, 16'sd0, (i % 2) ? 14'd16383 : 14'd0,
                (i % 3 == 0) ? -12'sd256 : 12'sd2047, (i % 4 == 0) ? 14'd16383 : 14'd0);
    end
    send_item(OP_APPEND, 16'sd0, 14'd16383, 12'sd2047, 14'd16383);
    send_cmd(OP_CLEAR, rand_temp());
  endtask

  function automatic logic [13:0] rand_ramp();
    case ($urandom_range(9))
      0: return 14'($urandom_range(16383));
      1: return 14'd16383;
      default: return 14'($urandom_range(3600, 16383));
    endcase
  endfunction

  function automatic logic [13:0] rand_hold();
    int r;
    r = $urandom_range(19);
    if (r < 14) return 14'd0;
    if (r < 19) return 14'd1;
    return 14'd2;
  endfunction

  // One well-formed profile: usually a clear, a few appended steps whose
  // targets wander by up to 30 degrees, a start near the first target, then
  // ticks whose measurements hover around the current target until the run
  // ends, is cut short, or is abandoned.
  task automatic run_profile();
    int n_new;
    int i;
    int goal;
    int first_goal;
    int off;
    int ticks;
    int tick_cap;
    if ($urandom_range(9) != 0) send_cmd(OP_CLEAR, rand_temp());
    n_new = ($urandom_range(11) == 0) ? TABLE_DEPTH + 1 : $urandom_range(1, 4);
    goal = rand_target();
    first_goal = goal;
    for (i = 0; i < n_new; i++) begin
      send_item(OP_APPEND, rand_temp(), rand_ramp(), 12'(goal), rand_hold());
      off = $urandom_range(60);
      goal = goal + off - 30;
      if (goal < -256) goal = -256;
      if (goal > 2047) goal = 2047;
    end
    if ($urandom_range(7) == 0) send_cmd(OP_START, rand_temp());
    else send_cmd(OP_START, temp_near(first_goal * 16, 200));
    tick_cap = $urandom_range(40, 300);
    ticks = 0;
    while (prof_steps != 0 && ticks < tick_cap) begin
      if (prof_cur < prof_steps) send_cmd(OP_TICK, temp_near(prof_goal_deg[prof_cur] * 16, 24));
      else send_cmd(OP_TICK, rand_temp());
      ticks++;
      if ($urandom_range(199) == 0) break;
    end
  endtask

  // Random phase: mostly complete profiles, about one time in ten a single
  // item with every field random. Between profiles the sender sometimes
  // holds off until every pending result has come back.
  task automatic test_random_profiles(input int pct, input int item_goal);
    int stop_at;
    idle_pct = pct;
    stop_at = items_taken + item_goal;
    while (items_taken < stop_at) begin
      if ($urandom_range(9) == 0) send_cmd(opcode_t'($urandom_range(3)), rand_temp());
      else run_profile();
      if ($urandom_range(7) == 0) wait_for_drain();
    end
    wait_for_drain();
  endtask

  initial begin
    repeat (4) @(posedge clk);
    @(negedge clk);
    rst <= 1'b0;

    test_empty_table();
    test_schedule_end();
    test_cooling_hold();
    test_full_table();

    // The block cannot stall its results, so only the sender idles.
    test_random_profiles(0, 500);
    test_random_profiles(85, 475);
    test_random_profiles(20, 475);

    wait_for_drain();
    repeat (4) @(posedge clk);
    if (mismatch_count == 0) begin
      $display("RESULT: OK");
    end else begin
      $display("RESULT: ERROR");
    end
    $finish;
  end

endmodule

`default_nettype wire

// ===== ramp_soak_setpoint_profiler.f =====
sv/rssp_pkg.sv
sv/rssp_ram.sv
sv/ramp_soak_setpoint_profiler.sv
dv/tb_ramp_soak_setpoint_profiler.sv
